// ===== hdl/pspi_pkg.sv =====
// Shared widths, limits and defaults for the parity strip peak interpolator.
`default_nettype none

package pspi_pkg;

    localparam int NUM_STRIPS_DEF = 16;
    localparam int PEAK_W         = 24;
    localparam int VAL_W          = 28;
    localparam int IDX_W          = 5;
    localparam int DIV_BITS       = 8;

    localparam int VAL_MAX_MAG    = 2 ** (VAL_W - 1) - 1;
    localparam int VAL_MIN_MAG    = 2 ** (VAL_W - 1);

    localparam logic [VAL_W-1:0] VAL_MAX_BITS = {1'b0, {(VAL_W - 1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN_BITS = {1'b1, {(VAL_W - 1){1'b0}}};

    typedef logic [PEAK_W-1:0] t_peak;
    typedef logic [VAL_W-1:0]  t_value;

endpackage

`default_nettype wire

// ===== hdl/parity_strip_peak_interpolator_top.sv =====
// Top level of the parity strip peak interpolator: loader, neighbour scan and shared datapath.
// Loading accepts one strip peak per cycle while o_stall is low; the beat for strip NUM_STRIPS starts the emit pass.
// Each strip then passes a scan exit, the plan, read and multiply-add states, the divider
// states and the output state, plus the scan steps that advance the neighbour search, and the
// output state waits while a held result stalls the output; no beat is taken meanwhile.
// Reset is synchronous and active low: it clears control state and sets odd-strip parity.
`default_nettype none

module parity_strip_peak_interpolator_top #(
    parameter int NUM_STRIPS = pspi_pkg::NUM_STRIPS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [pspi_pkg::PEAK_W-1:0]   i_strip_peak,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [pspi_pkg::IDX_W-1:0]         o_strip_index,
    output logic signed [pspi_pkg::VAL_W-1:0]  o_strip_value,
    output logic                               o_last_strip,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic                          i_cfg_data
);

    localparam int AW       = $clog2(NUM_STRIPS);
    localparam int DW       = $clog2(NUM_STRIPS);
    localparam int IW       = $clog2(NUM_STRIPS + 1);
    localparam int PW       = $clog2(NUM_STRIPS + 2);
    localparam int XW       = pspi_pkg::PEAK_W + 1;
    localparam int PRW      = XW + DW + 1;
    localparam int NUM_W    = PRW + 1;
    localparam int QW       = ((NUM_W + pspi_pkg::DIV_BITS - 1) / pspi_pkg::DIV_BITS)
                              * pspi_pkg::DIV_BITS;
    localparam int DIV_CYC  = QW / pspi_pkg::DIV_BITS;
    localparam int CW       = $clog2(DIV_CYC);

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_PLAN = 4'd2;
    localparam logic [3:0] S_RDA  = 4'd3;
    localparam logic [3:0] S_RDB  = 4'd4;
    localparam logic [3:0] S_MUL1 = 4'd5;
    localparam logic [3:0] S_MUL2 = 4'd6;
    localparam logic [3:0] S_ADD  = 4'd7;
    localparam logic [3:0] S_ABS  = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_SAT  = 4'd10;

    logic [3:0]                  r_state;
    logic [AW-1:0]               r_load_cnt;
    logic                        r_par;
    pspi_pkg::t_peak             r_mem [NUM_STRIPS];
    logic [NUM_STRIPS-1:0]       r_nz;
    pspi_pkg::t_peak             r_rd;
    logic [AW-1:0]               rd_addr;

    logic [IW-1:0]               r_s;
    logic [PW-1:0]               r_p;
    logic [IW-1:0]               r_lo1;
    logic [IW-1:0]               r_lo2;
    logic [IW-1:0]               r_hi1;
    logic [IW-1:0]               r_hi2;
    logic                        r_lo1_v;
    logic                        r_lo2_v;
    logic                        r_hi1_v;
    logic                        r_hi2_v;

    logic [IW-1:0]               r_ia;
    logic [IW-1:0]               r_ib;
    logic [DW-1:0]               r_d;
    logic [DW-1:0]               r_m;
    logic                        r_interp;
    pspi_pkg::t_peak             r_pa;
    logic signed [XW-1:0]        r_diff;
    logic signed [PRW-1:0]       r_acc;
    logic signed [PRW-1:0]       r_prod;
    logic signed [NUM_W-1:0]     r_num;
    logic                        r_neg;
    logic [QW-1:0]               r_q;
    logic [DW-1:0]               r_rem;
    logic [CW-1:0]               r_div_cnt;

    logic                        r_out_valid;
    logic [pspi_pkg::IDX_W-1:0]  r_out_index;
    pspi_pkg::t_value            r_out_value;
    logic                        r_out_last;

    logic signed [XW-1:0]        mult_x;
    logic [DW-1:0]               mult_y;
    logic signed [PRW-1:0]       prod;
    logic                        anchor_p;
    logic                        anchor_s;
    logic                        s_measured;
    logic signed [NUM_W-1:0]     half_d;
    logic signed [NUM_W-1:0]     n_mag;
    logic [QW-1:0]               n_q;
    logic [DW-1:0]               n_rem;
    logic [QW-1:0]               q_neg;
    pspi_pkg::t_value            n_value;

    assign o_stall       = (r_state != S_LOAD);
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_out_valid;
    assign o_strip_index = r_out_index;
    assign o_strip_value = r_out_value;
    assign o_last_strip  = r_out_last;

    assign anchor_p   = r_nz[AW'(r_p - 1'b1)] && (r_p[0] == r_par);
    assign anchor_s   = r_nz[AW'(r_s - 1'b1)] && (r_s[0] == r_par);
    assign s_measured = (r_s[0] == r_par);

    always_comb begin
        mult_x = '0;
        mult_y = '0;
        case (r_state)
            S_MUL1: begin
                mult_x = $signed({1'b0, r_pa});
                mult_y = r_d;
            end
            S_MUL2: begin
                mult_x = r_diff;
                mult_y = r_m;
            end
            default: begin
                mult_x = '0;
                mult_y = '0;
            end
        endcase
    end

    assign prod = PRW'(mult_x) * PRW'($signed({1'b0, mult_y}));

    assign rd_addr = (r_state == S_RDA) ? AW'(r_ia - 1'b1) : AW'(r_ib - 1'b1);

    assign half_d = $signed(NUM_W'(r_d >> 1));
    assign n_mag  = r_num[NUM_W-1] ? (half_d - r_num) : (r_num + half_d);

    always_comb begin
        logic [DW:0]   trial;
        logic [QW-1:0] q;
        logic [DW-1:0] rem;
        q   = r_q;
        rem = r_rem;
        for (int k = 0; k < pspi_pkg::DIV_BITS; k++) begin
            trial = {rem, q[QW-1]};
            q     = {q[QW-2:0], 1'b0};
            if (trial >= {1'b0, r_d}) begin
                trial = trial - {1'b0, r_d};
                q[0]  = 1'b1;
            end
            rem = trial[DW-1:0];
        end
        n_q   = q;
        n_rem = rem;
    end

    assign q_neg = -r_q;

    always_comb begin
        if (r_neg) begin
            if (r_q > QW'(pspi_pkg::VAL_MIN_MAG)) begin
                n_value = pspi_pkg::VAL_MIN_BITS;
            end else begin
                n_value = q_neg[pspi_pkg::VAL_W-1:0];
            end
        end else begin
            if (r_q > QW'(pspi_pkg::VAL_MAX_MAG)) begin
                n_value = pspi_pkg::VAL_MAX_BITS;
            end else begin
                n_value = r_q[pspi_pkg::VAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && i_valid) begin
            r_mem[r_load_cnt] <= i_strip_peak;
            r_nz[r_load_cnt]  <= |i_strip_peak;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_load_cnt  <= '0;
            r_par       <= 1'b1;
            r_out_valid <= 1'b0;
            r_lo1_v     <= 1'b0;
            r_lo2_v     <= 1'b0;
            r_hi1_v     <= 1'b0;
            r_hi2_v     <= 1'b0;
            r_div_cnt   <= '0;
            r_s         <= IW'(1);
            r_p         <= PW'(1);
        end else begin
            if (i_cfg_valid) begin
                r_par <= i_cfg_data;
            end
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (i_valid) begin
                        if (r_load_cnt == AW'(NUM_STRIPS - 1)) begin
                            r_load_cnt <= '0;
                            r_s        <= IW'(1);
                            r_p        <= PW'(1);
                            r_lo1_v    <= 1'b0;
                            r_lo2_v    <= 1'b0;
                            r_hi1_v    <= 1'b0;
                            r_hi2_v    <= 1'b0;
                            r_state    <= S_SCAN;
                        end else begin
                            r_load_cnt <= r_load_cnt + 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_p <= PW'(NUM_STRIPS) && !r_hi2_v) begin
                        if (anchor_p) begin
                            if (!r_hi1_v) begin
                                r_hi1   <= IW'(r_p);
                                r_hi1_v <= 1'b1;
                            end else begin
                                r_hi2   <= IW'(r_p);
                                r_hi2_v <= 1'b1;
                            end
                        end
                        r_p <= r_p + 1'b1;
                    end else begin
                        r_state <= S_PLAN;
                    end
                end
                S_PLAN: begin
                    r_interp <= 1'b0;
                    r_d      <= DW'(1);
                    r_m      <= '0;
                    r_ia     <= r_s;
                    r_ib     <= r_s;
                    if (!s_measured) begin
                        if (r_lo1_v && r_hi1_v) begin
                            r_interp <= 1'b1;
                            r_ia     <= r_lo1;
                            r_ib     <= r_hi1;
                            r_d      <= DW'(r_hi1 - r_lo1);
                            r_m      <= DW'(r_s - r_lo1);
                        end else if (r_lo1_v) begin
                            r_ia <= r_lo1;
                            r_ib <= r_lo1;
                            if (r_lo2_v) begin
                                r_ib <= r_lo2;
                                r_d  <= DW'(r_lo1 - r_lo2);
                                r_m  <= DW'(r_s - r_lo1);
                            end
                        end else if (r_hi1_v) begin
                            r_ia <= r_hi1;
                            r_ib <= r_hi1;
                            if (r_hi2_v) begin
                                r_ib <= r_hi2;
                                r_d  <= DW'(r_hi2 - r_hi1);
                                r_m  <= DW'(r_hi1 - r_s);
                            end
                        end
                    end
                    r_state <= S_RDA;
                end
                S_RDA: begin
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_pa    <= r_rd;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_acc   <= prod;
                    r_diff  <= r_interp ? ($signed({1'b0, r_rd}) - $signed({1'b0, r_pa}))
                                        : ($signed({1'b0, r_pa}) - $signed({1'b0, r_rd}));
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_prod  <= prod;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_num   <= NUM_W'(r_acc) + NUM_W'(r_prod);
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_neg     <= r_num[NUM_W-1];
                    r_q       <= QW'($unsigned(n_mag));
                    r_rem     <= '0;
                    r_div_cnt <= '0;
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    r_q   <= n_q;
                    r_rem <= n_rem;
                    if (r_div_cnt == CW'(DIV_CYC - 1)) begin
                        r_div_cnt <= '0;
                        r_state   <= S_SAT;
                    end else begin
                        r_div_cnt <= r_div_cnt + 1'b1;
                    end
                end
                S_SAT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_index <= pspi_pkg::IDX_W'(r_s);
                        r_out_value <= n_value;
                        r_out_last  <= (r_s == IW'(NUM_STRIPS));
                        if (anchor_s) begin
                            r_lo1   <= r_s;
                            r_lo1_v <= 1'b1;
                            r_lo2   <= r_lo1;
                            r_lo2_v <= r_lo1_v;
                        end
                        if (r_hi1_v && r_hi1 == r_s) begin
                            r_hi1   <= r_hi2;
                            r_hi1_v <= r_hi2_v;
                            r_hi2_v <= 1'b0;
                        end
                        if (r_s == IW'(NUM_STRIPS)) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_s     <= r_s + 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    a_hi_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hi1_v && r_hi2_v |-> r_hi1 < r_hi2)
        else $error("upper neighbour list out of order");

    a_lo_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo1_v && r_lo2_v |-> r_lo2 < r_lo1)
        else $error("lower neighbour list out of order");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_d)
        else $error("divider remainder not below divisor");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_strip |-> o_strip_index == pspi_pkg::IDX_W'(NUM_STRIPS))
        else $error("final strip flagged on wrong index");

endmodule

`default_nettype wire
